/* sv/complex_arithmetic_unit_defines.svh */
// ============================================================================
// Assertion macros for the complex arithmetic unit
// Shared concurrent-check wrappers clocked on aclk and disabled in reset.
// ============================================================================
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication checked at every rising edge of aclk.
`define CAU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every rising edge of aclk.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/cau_pkg.sv */
// ============================================================================
// Complex arithmetic unit package
// Fixed-point format, datapath widths, types and action codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int QBITS     = 32;
    localparam int REM_W     = 64;
    localparam int DIVW      = REM_W + FRAC_BITS;

    typedef logic [REM_W-1:0]  rem_t;
    typedef logic [QBITS-1:0]  quo_t;
    typedef logic [DATA_W:0]   mag_t;
    typedef logic [DIVW-1:0]   divw_t;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_NEG = 3'd4,
        ACT_CMP = 3'd5
    } action_t;

endpackage

`default_nettype wire

/* sv/complex_arithmetic_unit.sv */
// ============================================================================
// Complex arithmetic unit
// Stateless Q16.16 complex ALU: add, subtract, multiply, divide, negate and
// compare, with saturation and divide-by-zero reporting.
// ============================================================================
// Path: stages A, B, C and D, the divider chain, then the output register.
// Throughput: one word per cycle while the output does not stall; the 32-stage divider chain sets the depth.
// The whole pipeline advances together and holds while the output stalls.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [2:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_re, res_im
    output logic [2:0]   m_tuser    // is_equal, divide_by_zero, overflow
);
    import cau_pkg::*;

    typedef struct packed {
        action_t act;
        logic    neg_re;
        logic    neg_im;
        mag_t    fmag_re;
        mag_t    fmag_im;
        logic    dovf_re;
        logic    dovf_im;
        logic    dz;
        logic    eq;
    } side_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } pack_t;

    function automatic pack_t pack_part(input logic neg, input mag_t mag);
        mag_t  lim;
        mag_t  m;
        pack_t r;
        lim   = neg ? mag_t'(33'h0_8000_0000) : mag_t'(33'h0_7FFF_FFFF);
        r.ovf = 1'b0;
        m     = mag;
        if (mag > lim) begin
            m     = lim;
            r.ovf = 1'b1;
        end
        r.val = neg ? DATA_W'(mag_t'(0) - m) : m[DATA_W-1:0];
        if (mag == '0) begin
            r.val = '0;
        end
        return r;
    endfunction

    function automatic rem_t abs65(input logic [REM_W:0] v);
        logic [REM_W:0] a;
        a = v[REM_W] ? (~v + 1'b1) : v;
        return a[REM_W-1:0];
    endfunction

    function automatic mag_t clamp_mag(input rem_t v);
        mag_t r;
        if (|v[REM_W-1:DATA_W]) begin
            r = {1'b1, {DATA_W{1'b0}}};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

    logic adv;

    // Stage A: input capture
    logic                     vld_a_reg;
    action_t                  act_a_reg;
    logic signed [DATA_W-1:0] ar_a_reg, ai_a_reg, br_a_reg, bi_a_reg;

    // Stage B: products and linear results
    logic                     vld_b_reg;
    action_t                  act_b_reg;
    logic signed [63:0]       p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;
    logic signed [DATA_W:0]   lin_re_reg, lin_im_reg;
    logic                     eq_b_reg;
    logic signed [DATA_W:0]   lin_re_next, lin_im_next;

    // Stage C: sums
    logic                     vld_c_reg;
    action_t                  act_c_reg;
    logic [REM_W:0]           v_re_reg, v_im_reg;
    rem_t                     den_c_reg;
    logic                     eq_c_reg;
    logic [REM_W:0]           v_re_next, v_im_next;

    // Stage D: sign-magnitude and divider setup
    logic                     vld_d_reg;
    side_t                    side_d_reg;
    rem_t                     rem_re_reg, rem_im_reg, den_d_reg;
    quo_t                     low_re_reg, low_im_reg;
    side_t                    side_d_next;
    rem_t                     mag_re, mag_im;
    divw_t                    dfull_re, dfull_im;

    // Divider alignment line
    logic  [QBITS-1:0]        vld_q_reg;
    side_t                    side_q_reg [QBITS];
    quo_t                     quo_re, quo_im;

    // Output
    logic                     m_tvalid_reg;
    logic [63:0]              m_tdata_reg;
    logic [2:0]               m_tuser_reg;
    mag_t                     fin_mag_re, fin_mag_im;
    pack_t                    pk_re, pk_im;
    side_t                    side_o;
    logic                     zero_no_ovf;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- Stage B logic ----------------
    always_comb begin
        lin_re_next = '0;
        lin_im_next = '0;
        case (act_a_reg)
            ACT_ADD: begin
                lin_re_next = {ar_a_reg[DATA_W-1], ar_a_reg} + {br_a_reg[DATA_W-1], br_a_reg};
                lin_im_next = {ai_a_reg[DATA_W-1], ai_a_reg} + {bi_a_reg[DATA_W-1], bi_a_reg};
            end
            ACT_SUB: begin
                lin_re_next = {ar_a_reg[DATA_W-1], ar_a_reg} - {br_a_reg[DATA_W-1], br_a_reg};
                lin_im_next = {ai_a_reg[DATA_W-1], ai_a_reg} - {bi_a_reg[DATA_W-1], bi_a_reg};
            end
            ACT_NEG: begin
                lin_re_next = '0 - {ar_a_reg[DATA_W-1], ar_a_reg};
                lin_im_next = '0 - {ai_a_reg[DATA_W-1], ai_a_reg};
            end
            default: begin
                lin_re_next = '0;
                lin_im_next = '0;
            end
        endcase
    end

    // ---------------- Stage C logic ----------------
    always_comb begin
        v_re_next = '0;
        v_im_next = '0;
        case (act_b_reg)
            ACT_ADD, ACT_SUB, ACT_NEG: begin
                v_re_next = {{(REM_W-DATA_W){lin_re_reg[DATA_W]}}, lin_re_reg};
                v_im_next = {{(REM_W-DATA_W){lin_im_reg[DATA_W]}}, lin_im_reg};
            end
            ACT_MUL: begin
                v_re_next = {p_rr_reg[63], p_rr_reg} - {p_ii_reg[63], p_ii_reg};
                v_im_next = {p_ri_reg[63], p_ri_reg} + {p_ir_reg[63], p_ir_reg};
            end
            ACT_DIV: begin
                v_re_next = {p_rr_reg[63], p_rr_reg} + {p_ii_reg[63], p_ii_reg};
                v_im_next = {p_ir_reg[63], p_ir_reg} - {p_ri_reg[63], p_ri_reg};
            end
            default: begin
                v_re_next = '0;
                v_im_next = '0;
            end
        endcase
    end

    // ---------------- Stage D logic ----------------
    always_comb begin
        mag_re   = abs65(v_re_reg);
        mag_im   = abs65(v_im_reg);
        dfull_re = divw_t'(mag_re) << FRAC_BITS;
        dfull_im = divw_t'(mag_im) << FRAC_BITS;

        side_d_next.act    = act_c_reg;
        side_d_next.neg_re = v_re_reg[REM_W];
        side_d_next.neg_im = v_im_reg[REM_W];
        if (act_c_reg == ACT_MUL) begin
            // Truncation toward zero: shift the magnitude, not the signed value.
            side_d_next.fmag_re = clamp_mag(mag_re >> FRAC_BITS);
            side_d_next.fmag_im = clamp_mag(mag_im >> FRAC_BITS);
        end else begin
            side_d_next.fmag_re = clamp_mag(mag_re);
            side_d_next.fmag_im = clamp_mag(mag_im);
        end
        // A quotient of 2^32 or more shows as a high part not below the divisor.
        side_d_next.dovf_re = rem_t'(dfull_re[DIVW-1:QBITS]) >= den_c_reg;
        side_d_next.dovf_im = rem_t'(dfull_im[DIVW-1:QBITS]) >= den_c_reg;
        side_d_next.dz      = (act_c_reg == ACT_DIV) && (den_c_reg == '0);
        side_d_next.eq      = eq_c_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg    <= 1'b0;
            vld_b_reg    <= 1'b0;
            vld_c_reg    <= 1'b0;
            vld_d_reg    <= 1'b0;
            vld_q_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_a_reg    <= s_tvalid;
            vld_b_reg    <= vld_a_reg;
            vld_c_reg    <= vld_b_reg;
            vld_d_reg    <= vld_c_reg;
            vld_q_reg    <= {vld_q_reg[QBITS-2:0], vld_d_reg};
            m_tvalid_reg <= vld_q_reg[QBITS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            act_a_reg  <= action_t'(s_tuser);
            ar_a_reg   <= s_tdata[31:0];
            ai_a_reg   <= s_tdata[63:32];
            br_a_reg   <= s_tdata[95:64];
            bi_a_reg   <= s_tdata[127:96];

            act_b_reg  <= act_a_reg;
            p_rr_reg   <= ar_a_reg * br_a_reg;
            p_ii_reg   <= ai_a_reg * bi_a_reg;
            p_ri_reg   <= ar_a_reg * bi_a_reg;
            p_ir_reg   <= ai_a_reg * br_a_reg;
            sq_r_reg   <= br_a_reg * br_a_reg;
            sq_i_reg   <= bi_a_reg * bi_a_reg;
            lin_re_reg <= lin_re_next;
            lin_im_reg <= lin_im_next;
            eq_b_reg   <= (act_a_reg == ACT_CMP) && (ar_a_reg == br_a_reg)
                          && (ai_a_reg == bi_a_reg);

            act_c_reg  <= act_b_reg;
            v_re_reg   <= v_re_next;
            v_im_reg   <= v_im_next;
            den_c_reg  <= rem_t'(sq_r_reg) + rem_t'(sq_i_reg);
            eq_c_reg   <= eq_b_reg;

            side_d_reg <= side_d_next;
            rem_re_reg <= rem_t'(dfull_re[DIVW-1:QBITS]);
            rem_im_reg <= rem_t'(dfull_im[DIVW-1:QBITS]);
            low_re_reg <= dfull_re[QBITS-1:0];
            low_im_reg <= dfull_im[QBITS-1:0];
            den_d_reg  <= den_c_reg;

            side_q_reg[0] <= side_d_reg;
            for (int i = 1; i < QBITS; i++) begin
                side_q_reg[i] <= side_q_reg[i-1];
            end

            m_tdata_reg <= {pk_im.val, pk_re.val};
            m_tuser_reg <= {pk_re.ovf | pk_im.ovf, side_o.dz, side_o.eq};
        end
    end

    cau_divider u_div_re (
        .aclk    (aclk),
        .en      (adv),
        .rem_in  (rem_re_reg),
        .low_in  (low_re_reg),
        .den_in  (den_d_reg),
        .quo_out (quo_re)
    );

    cau_divider u_div_im (
        .aclk    (aclk),
        .en      (adv),
        .rem_in  (rem_im_reg),
        .low_in  (low_im_reg),
        .den_in  (den_d_reg),
        .quo_out (quo_im)
    );

    // ---------------- Output selection ----------------
    always_comb begin
        side_o = side_q_reg[QBITS-1];
        case (side_o.act)
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_NEG: begin
                fin_mag_re = side_o.fmag_re;
                fin_mag_im = side_o.fmag_im;
            end
            ACT_DIV: begin
                if (side_o.dz) begin
                    fin_mag_re = '0;
                    fin_mag_im = '0;
                end else begin
                    fin_mag_re = side_o.dovf_re ? {1'b1, {DATA_W{1'b0}}} : {1'b0, quo_re};
                    fin_mag_im = side_o.dovf_im ? {1'b1, {DATA_W{1'b0}}} : {1'b0, quo_im};
                end
            end
            default: begin
                fin_mag_re = '0;
                fin_mag_im = '0;
            end
        endcase
        pk_re = pack_part(side_o.neg_re, fin_mag_re);
        pk_im = pack_part(side_o.neg_im, fin_mag_im);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- Assertions ----------------
    assign zero_no_ovf = (m_tdata == '0) && !m_tuser[2];

    `CAU_ASSERT_SAME(a_dz_zero, m_tvalid && m_tuser[1], zero_no_ovf, "nonzero divide-by-zero word")
    `CAU_ASSERT_SAME(a_eq_zero, m_tvalid && m_tuser[0], zero_no_ovf && !m_tuser[1], "bad compare word")
    `CAU_ASSERT_SAME(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    `CAU_ASSERT_NEXT(a_pipe_hold, !adv, $stable(vld_q_reg) && $stable(vld_d_reg), "stall moved valid")

endmodule

`default_nettype wire

/* sv/cau_divider.sv */
// ============================================================================
// Pipelined restoring divider
// One quotient bit per register stage; the partial remainder, the remaining
// dividend bits and the divisor move down the chain together.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cau_divider (
    input  logic          aclk,
    input  logic          en,
    input  cau_pkg::rem_t rem_in,
    input  cau_pkg::quo_t low_in,
    input  cau_pkg::rem_t den_in,
    output cau_pkg::quo_t quo_out
);
    import cau_pkg::*;

    // The last stage keeps only its quotient, so the other chains are one shorter.
    rem_t             rem_reg  [QBITS-1];
    quo_t             low_reg  [QBITS-1];
    rem_t             den_reg  [QBITS-1];
    quo_t             quo_reg  [QBITS];
    rem_t             rem_next [QBITS-1];
    logic [QBITS-1:0] take_vec;

    // The remainder stays below the divisor, so the trial fits one extra bit.
    always_comb begin
        logic [REM_W:0] trial;
        trial       = {rem_in, low_in[QBITS-1]};
        take_vec[0] = trial >= {1'b0, den_in};
        rem_next[0] = take_vec[0] ? rem_t'(trial - {1'b0, den_in}) : rem_t'(trial);
        for (int i = 1; i < QBITS-1; i++) begin
            trial       = {rem_reg[i-1], low_reg[i-1][QBITS-1]};
            take_vec[i] = trial >= {1'b0, den_reg[i-1]};
            rem_next[i] = take_vec[i] ? rem_t'(trial - {1'b0, den_reg[i-1]}) : rem_t'(trial);
        end
        trial             = {rem_reg[QBITS-2], low_reg[QBITS-2][QBITS-1]};
        take_vec[QBITS-1] = trial >= {1'b0, den_reg[QBITS-2]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            low_reg[0] <= low_in << 1;
            den_reg[0] <= den_in;
            quo_reg[0] <= quo_t'(take_vec[0]);
            for (int i = 0; i < QBITS-1; i++) begin
                rem_reg[i] <= rem_next[i];
            end
            for (int i = 1; i < QBITS-1; i++) begin
                low_reg[i] <= low_reg[i-1] << 1;
                den_reg[i] <= den_reg[i-1];
            end
            for (int i = 1; i < QBITS; i++) begin
                quo_reg[i] <= {quo_reg[i-1][QBITS-2:0], take_vec[i]};
            end
        end
    end

    assign quo_out = quo_reg[QBITS-1];

endmodule

`default_nettype wire
